// ----- src/btb_pkg.sv -----
// ----------------------------------------------------------------------------
// btb_pkg
// Shared types and constants for the branch target buffer predictor.
// ----------------------------------------------------------------------------
package btb_pkg;

   // entry count, power of two
   localparam int TABLE_ENTRIES = 4;
   localparam int IDX_W         = $clog2(TABLE_ENTRIES);
   localparam int ALIGN_SHIFT   = 2;
   localparam int TAG_W         = 32 - ALIGN_SHIFT - IDX_W;

   localparam logic [6:0]  OPCODE_JUMP = 7'h6f;
   localparam logic [31:0] SEQ_STEP    = 32'd4;

   localparam int CSR_ADDR_W = 3;
   localparam logic [CSR_ADDR_W-ALIGN_SHIFT-1:0] REG_PREDICT_MODE = '0;

   localparam logic MODE_SEQUENTIAL = 1'b0;
   localparam logic MODE_BTFN       = 1'b1;

   typedef logic [IDX_W-1:0] idx_type;
   typedef logic [TAG_W-1:0] tag_type;

   // controller -> datapath
   typedef struct packed {
      logic load;     // latch request beat, read the table
      logic resolve;  // predict, register result, update the table
   } btb_cmd_type;

   function automatic idx_type idx_of(input logic [31:0] pc);
      return pc[ALIGN_SHIFT +: IDX_W];
   endfunction

   function automatic tag_type tag_of(input logic [31:0] pc);
      return pc[31 -: TAG_W];
   endfunction

endpackage

// ----- src/btb_if.sv -----
// ----------------------------------------------------------------------------
// btb_if
// Valid/ready channels for branch records and prediction results.
// ----------------------------------------------------------------------------
interface btb_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] pc;
   logic [31:0] instr_word;
   logic [31:0] actual_next_pc;

   modport source (output valid, output pc, output instr_word, output actual_next_pc,
                   input ready);
   modport sink   (input valid, input pc, input instr_word, input actual_next_pc,
                   output ready);
endinterface

interface btb_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] predicted_next_pc;
   logic        table_hit;
   logic        mispredicted;

   modport source (output valid, output predicted_next_pc, output table_hit,
                   output mispredicted, input ready);
   modport sink   (input valid, input predicted_next_pc, input table_hit,
                   input mispredicted, output ready);
endinterface

// ----- src/btb_ctrl.sv -----
// ----------------------------------------------------------------------------
// btb_ctrl
// Sequencer: accept a record beat, resolve it, hold the result beat.
// ----------------------------------------------------------------------------
module btb_ctrl
   import btb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output btb_cmd_type cmd
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_LOOK,
      S_RESP
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      accept;

   // a new beat may enter as the pending result leaves
   assign req_ready = !reset && ((state_ff == S_IDLE) ||
                                 (state_ff == S_RESP && rsp_ready));
   assign accept    = req_valid && req_ready;

   assign cmd.load    = accept;
   assign cmd.resolve = (state_ff == S_LOOK);
   assign rsp_valid   = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_LOOK;
            end
         end
         S_LOOK: begin
            state_in     = S_RESP;
            rsp_valid_in = 1'b1;
         end
         S_RESP: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               state_in     = accept ? S_LOOK : S_IDLE;
            end
         end
         default: begin
            state_in     = S_IDLE;
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ----- src/btb_dp.sv -----
// ----------------------------------------------------------------------------
// btb_dp
// Datapath: table storage, lookup, sequential or BTFN prediction and table update.
// ----------------------------------------------------------------------------
module btb_dp
   import btb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  btb_cmd_type cmd,
   input  logic        predict_mode,
   input  logic [31:0] req_pc,
   input  logic [31:0] req_instr_word,
   input  logic [31:0] req_actual_next_pc,
   output logic [31:0] rsp_predicted_next_pc,
   output logic        rsp_table_hit,
   output logic        rsp_mispredicted
);

   // table storage
   tag_type     tag_mem    [TABLE_ENTRIES];
   logic [31:0] target_mem [TABLE_ENTRIES];
   logic        jump_mem   [TABLE_ENTRIES];
   logic [TABLE_ENTRIES-1:0] valid_ff;

   // latched record
   logic [31:0] pc_ff;
   logic [31:0] actual_ff;
   logic        is_jump_ff;
   idx_type     idx_ff;

   // registered table read
   tag_type     rd_tag_ff;
   logic [31:0] rd_target_ff;
   logic        rd_jump_ff;

   // result
   logic [31:0] pred_ff;
   logic        hit_ff;
   logic        miss_ff;

   logic [31:0] seq_pc;
   logic        hit;
   logic        take;
   logic [31:0] pred;
   logic        update;

   assign seq_pc = pc_ff + SEQ_STEP;
   assign hit    = valid_ff[idx_ff] && (rd_tag_ff == tag_of(pc_ff));
   assign take   = (predict_mode == MODE_BTFN) && hit &&
                   (rd_jump_ff || (rd_target_ff < pc_ff));
   assign pred   = take ? rd_target_ff : seq_pc;
   assign update = cmd.resolve && (actual_ff != seq_pc);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         pc_ff        <= req_pc;
         actual_ff    <= req_actual_next_pc;
         is_jump_ff   <= (req_instr_word[6:0] == OPCODE_JUMP);
         idx_ff       <= idx_of(req_pc);
         rd_tag_ff    <= tag_mem[idx_of(req_pc)];
         rd_target_ff <= target_mem[idx_of(req_pc)];
         rd_jump_ff   <= jump_mem[idx_of(req_pc)];
      end
      if (cmd.resolve) begin
         pred_ff <= pred;
         hit_ff  <= hit;
         miss_ff <= (pred != actual_ff);
      end
      if (update) begin
         tag_mem[idx_ff]    <= tag_of(pc_ff);
         target_mem[idx_ff] <= actual_ff;
         jump_mem[idx_ff]   <= is_jump_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (update) begin
         valid_ff[idx_ff] <= 1'b1;
      end
   end

   assign rsp_predicted_next_pc = pred_ff;
   assign rsp_table_hit         = hit_ff;
   assign rsp_mispredicted      = miss_ff;

endmodule

// ----- src/btb_btfn_predictor.sv -----
// ----------------------------------------------------------------------------
// btb_btfn_predictor
// Direct-mapped branch target buffer with backward-taken/forward-not-taken
// prediction, scored against retired control-flow records.
// ----------------------------------------------------------------------------
// Usage:
//   req_bus carries one retired record per beat (pc, instr_word,
//   actual_next_pc); rsp_bus returns one beat per record with the prediction
//   made before the record updates the table, the hit flag and the
//   mispredict flag. Results come back in order.
//   A result beat shows in S_RESP, after the table read and S_LOOK resolve.
//   No record is taken in S_LOOK, the resolve/update step that follows
//   the synchronous table read; a new record is taken in the cycle the
//   pending result beat is consumed.
//   If rsp_ready stays low the result beat holds and req_ready stays low.
//   Reset clears all table valid bits and sets predict_mode to 1 (BTFN);
//   the table is usable the cycle after reset falls.
//   csr_*: APB-style; predict_mode at byte address 0, write only while idle.
// ----------------------------------------------------------------------------
module btb_btfn_predictor
   import btb_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   btb_req_if.sink               req_bus,
   btb_rsp_if.source             rsp_bus,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   btb_cmd_type cmd;
   logic        mode_ff;
   logic        csr_hit;

   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[CSR_ADDR_W-1:ALIGN_SHIFT] == REG_PREDICT_MODE);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_BTFN;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_hit) begin
         mode_ff <= csr_pwdata[0];
      end
   end

   assign csr_prdata = csr_hit ? {31'd0, mode_ff} : 32'd0;

   btb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .cmd       (cmd)
   );

   btb_dp u_dp (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .predict_mode          (mode_ff),
      .req_pc                (req_bus.pc),
      .req_instr_word        (req_bus.instr_word),
      .req_actual_next_pc    (req_bus.actual_next_pc),
      .rsp_predicted_next_pc (rsp_bus.predicted_next_pc),
      .rsp_table_hit         (rsp_bus.table_hit),
      .rsp_mispredicted      (rsp_bus.mispredicted)
   );

endmodule

// ----- src/btb_chk.sv -----
// ----------------------------------------------------------------------------
// btb_chk
// Port-level checks on beat ordering and timing of the predictor.
// ----------------------------------------------------------------------------
module btb_chk (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready
);

   // a stalled result beat is not dropped
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result beat dropped while stalled");

   // every accepted record yields its result beat after its table read and resolve
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |-> ##2 rsp_valid)
      else $error("result beat missing two cycles after accept");

   // no result beat in the cycle right after an accept
   a_no_early: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !rsp_valid)
      else $error("result beat too early");

   // no new record while a result beat is stuck
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("record accepted over a stalled result");

endmodule

bind btb_btfn_predictor btb_chk u_btb_chk (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_bus.valid),
   .req_ready (req_bus.ready),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready)
);
